@@ rtl/core/fsld_pkg.sv @@
// package: fixed-point formats, log-domain tables and helper functions
package fsld_pkg;

  localparam int FRAC_BITS       = 8;
  localparam int STEP_BITS       = 4;
  localparam int LOG_TABLE_DEPTH = 256;
  localparam int IDX_W           = $clog2(LOG_TABLE_DEPTH);
  localparam int SUM_W           = 24;
  localparam int LOG_W           = 16;
  localparam int TAB_W           = 16;
  localparam int DIFF_W          = SUM_W + 1;
  localparam int WIDE_W          = SUM_W + 2;
  localparam int CFG_IDX_W       = 8;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_MODE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CEILING = CFG_IDX_W'(1);

  localparam logic signed [LOG_W-1:0] CEILING_RESET = LOG_W'(25600);

  localparam longint unsigned Q30_ONE = 64'd1 << 30;

  typedef enum logic {
    MODE_MASK = 1'b0,
    MODE_SNR  = 1'b1
  } mode_e;

  typedef logic [TAB_W-1:0] tab_t [LOG_TABLE_DEPTH];

  // one classified bin on its way from front to back
  typedef struct packed {
    logic signed [SUM_W-1:0] clean;
    logic signed [SUM_W-1:0] other;
    logic                    last;
    mode_e                   mode;
  } bin_t;

  // queue occupancy seen by the top level
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // unsigned quotient by shift and subtract, only evaluated on constants
  function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
    longint unsigned q, rem;
    q   = 0;
    rem = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem  = rem - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // -ln(m) in Q30 for m in [1/2, 1], atanh series
  function automatic longint unsigned neg_ln_q30(longint unsigned m_in);
    longint unsigned m, z, z2, term, acc;
    m = m_in;
    if (m > Q30_ONE) m = Q30_ONE;
    if (m < (Q30_ONE >> 1)) m = Q30_ONE >> 1;
    z    = div_u64((Q30_ONE - m) << 30, Q30_ONE + m);
    z2   = (z * z) >> 30;
    term = z;
    acc  = 0;
    for (int n = 0; n < 16; n++) begin
      acc  = acc + div_u64(term, longint'(2 * n + 1));
      term = (term * z2) >> 30;
    end
    return 2 * acc;
  endfunction

  function automatic longint unsigned neg_ln_any(longint unsigned w_in, longint unsigned ln2);
    longint unsigned w, k;
    w = w_in;
    k = 0;
    if (w == 0) w = 1;
    while (w < (Q30_ONE >> 1)) begin
      w = w << 1;
      k = k + 1;
    end
    return neg_ln_q30(w) + k * ln2;
  endfunction

  // exp(-2^-sh) in Q30
  function automatic longint unsigned exp_neg_q30(int sh);
    longint unsigned sum, term;
    sum  = Q30_ONE;
    term = Q30_ONE;
    for (int n = 1; n < 20; n++) begin
      term = div_u64(term >> sh, longint'(n));
      sum  = sum + term;
    end
    return div_u64(64'd1 << 60, sum);
  endfunction

  function automatic logic [TAB_W-1:0] q30_to_fix(longint unsigned v);
    longint unsigned r;
    r = (v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    return r[TAB_W-1:0];
  endfunction

  // sel 0: ln(1+exp(-x)), sel 1: -ln(1-exp(-x)), sampled at bin centers
  function automatic tab_t build_tab(bit sel);
    tab_t            t;
    longint unsigned ln2, y, r, na, la;
    ln2 = neg_ln_q30(Q30_ONE >> 1);
    y   = exp_neg_q30(STEP_BITS + 1);
    r   = exp_neg_q30(STEP_BITS);
    for (int i = 0; i < LOG_TABLE_DEPTH; i++) begin
      na = neg_ln_q30((Q30_ONE + y) >> 1);
      la = (ln2 > na) ? ln2 - na : 64'd0;
      t[i] = sel ? q30_to_fix(neg_ln_any(Q30_ONE - y, ln2)) : q30_to_fix(la);
      y = (y * r) >> 30;
    end
    return t;
  endfunction

  localparam tab_t ADD_TAB = build_tab(1'b0);
  localparam tab_t SUB_TAB = build_tab(1'b1);

  function automatic logic [TAB_W-1:0] tab_read(tab_t t, logic [DIFF_W-1:0] d);
    logic [DIFF_W-1:0] idx;
    idx = d >> (FRAC_BITS - STEP_BITS);
    if (idx >= DIFF_W'(LOG_TABLE_DEPTH)) return '0;
    return t[idx[IDX_W-1:0]];
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_sum(logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi, lo;
    hi = WIDE_W'((64'sd1 <<< (SUM_W - 1)) - 1);
    lo = -hi - WIDE_W'(1);
    if (v > hi) return hi[SUM_W-1:0];
    if (v < lo) return lo[SUM_W-1:0];
    return v[SUM_W-1:0];
  endfunction

  function automatic logic signed [LOG_W-1:0] sat_log(logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi, lo;
    hi = WIDE_W'((64'sd1 <<< (LOG_W - 1)) - 1);
    lo = -hi - WIDE_W'(1);
    if (v > hi) return hi[LOG_W-1:0];
    if (v < lo) return lo[LOG_W-1:0];
    return v[LOG_W-1:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] log_add(logic signed [SUM_W-1:0] a,
                                                      logic signed [SUM_W-1:0] b);
    logic signed [SUM_W-1:0]  hi, lo;
    logic signed [WIDE_W-1:0] d;
    hi = (a > b) ? a : b;
    lo = (a > b) ? b : a;
    d  = WIDE_W'(hi) - WIDE_W'(lo);
    return sat_sum(WIDE_W'(hi) + $signed({{(WIDE_W-TAB_W){1'b0}},
                   tab_read(ADD_TAB, d[DIFF_W-1:0])}));
  endfunction

endpackage

@@ rtl/core/fsld_if.sv @@
// channel interfaces: bin input, result output, register writes
interface fsld_bin_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] noisy_log_energy;
  logic signed [15:0] prediction;
  logic               last_bin;
  modport source (output valid, noisy_log_energy, prediction, last_bin, input ready);
  modport sink (input valid, noisy_log_energy, prediction, last_bin, output ready);
endinterface

interface fsld_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] frame_snr;
  modport source (output valid, frame_snr, input ready);
  modport sink (input valid, frame_snr, output ready);
endinterface

interface fsld_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/frame_snr_log_domain.sv @@
// top level: frame log snr estimator in the log domain
//
//  channel | dir | payload                                  | transfer when
//  bin_i   | in  | noisy_log_energy, prediction, last_bin   | valid & ready
//  snr_o   | out | frame_snr                                | valid & ready
//  cfg_i   | in  | index (0 mode, 1 snr_ceiling), data      | valid & ready
//
// one bin per cycle while the queue is not full; the accumulator loop (compare, table, add, clamp) sets it
// a frame result passes through the queue, the finished-totals register and the output register
// reset: mode mask, ceiling 25600, next bin starts a frame, no result pending
// front and back stall on their own through a two-entry queue
// cfg_i is always ready
module frame_snr_log_domain (
  input logic         clk_i,
  input logic         rst_ni,
  fsld_bin_if.sink    bin_i,
  fsld_res_if.source  snr_o,
  fsld_cfg_if.sink    cfg_i
);
  import fsld_pkg::*;

  mode_e                   mode_q, mode_d;
  logic signed [LOG_W-1:0] ceil_q, ceil_d;
  bin_t                    front_bin, back_bin;
  q_stat_t                 q_stat;
  logic                    push, pop;

  // register writes
  assign cfg_i.ready = 1'b1;

  always_comb begin
    mode_d = mode_q;
    ceil_d = ceil_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_MODE:    mode_d = mode_e'(cfg_i.data[0]);
        REG_CEILING: ceil_d = cfg_i.data;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_MASK;
      ceil_q <= CEILING_RESET;
    end else begin
      mode_q <= mode_d;
      ceil_q <= ceil_d;
    end
  end

  // front: classify each bin under the current mode
  fsld_front u_front (
    .mode_i    (mode_q),
    .ceiling_i (ceil_q),
    .noisy_i   (bin_i.noisy_log_energy),
    .pred_i    (bin_i.prediction),
    .last_i    (bin_i.last_bin),
    .bin_o     (front_bin)
  );

  assign bin_i.ready = !q_stat.full;
  assign push        = bin_i.valid && !q_stat.full;

  fsld_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_bin),
    .pop_i       (pop),
    .pop_data_o  (back_bin),
    .stat_o      (q_stat)
  );

  // back: accumulate, finish the frame, hold the result
  fsld_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ceiling_i   (ceil_q),
    .q_valid_i   (!q_stat.empty),
    .q_data_i    (back_bin),
    .pop_o       (pop),
    .res_valid_o (snr_o.valid),
    .res_ready_i (snr_o.ready),
    .res_o       (snr_o.frame_snr)
  );

`ifndef ASSERT_OFF
  a_push_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> !q_stat.empty) else $error("queue empty after bin transfer");

  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.empty |-> !pop) else $error("pop from empty queue");

  a_full_stalls : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.full |-> !bin_i.ready) else $error("ready while queue full");
`endif

endmodule

@@ rtl/core/fsld_front.sv @@
// front: forms the clean and noise log bins of one input bin
module fsld_front (
  input  fsld_pkg::mode_e                   mode_i,
  input  logic signed [fsld_pkg::LOG_W-1:0] ceiling_i,
  input  logic signed [fsld_pkg::LOG_W-1:0] noisy_i,
  input  logic signed [fsld_pkg::LOG_W-1:0] pred_i,
  input  logic                              last_i,
  output fsld_pkg::bin_t                    bin_o
);
  import fsld_pkg::*;

  localparam int SP_W = LOG_W + 2;
  localparam int DB_W = LOG_W + 4;

  logic signed [LOG_W-1:0] s;
  logic signed [SP_W-1:0]  s_ext, pos_part, neg_part, sp_pos, sp_neg, a_ext;
  logic        [TAB_W-1:0] a_val;
  logic signed [DB_W-1:0]  c_snr, n_snr;
  logic signed [LOG_W:0]   c_mask;

  always_comb begin
    s        = (pred_i > ceiling_i) ? ceiling_i : pred_i;
    s_ext    = SP_W'(s);
    pos_part = (s > 0) ? s_ext : '0;
    neg_part = (s < 0) ? -s_ext : '0;
    a_val    = tab_read(ADD_TAB, DIFF_W'(pos_part | neg_part));
    a_ext    = $signed({{(SP_W-TAB_W){1'b0}}, a_val});
    sp_pos   = pos_part + a_ext;
    sp_neg   = neg_part + a_ext;
    c_snr    = (DB_W'(noisy_i) - DB_W'(sp_neg)) <<< 1;
    n_snr    = (DB_W'(noisy_i) - DB_W'(sp_pos)) <<< 1;
    c_mask   = ((pred_i < 0) ? (LOG_W+1)'(pred_i) : '0) + (LOG_W+1)'(noisy_i);
  end

  always_comb begin
    bin_o.last = last_i;
    bin_o.mode = mode_i;
    if (mode_i == MODE_SNR) begin
      bin_o.clean = SUM_W'(c_snr);
      bin_o.other = SUM_W'(n_snr);
    end else begin
      bin_o.clean = SUM_W'(c_mask);
      bin_o.other = SUM_W'(noisy_i);
    end
  end

endmodule

@@ rtl/core/fsld_queue.sv @@
// small fifo between front and back
module fsld_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  fsld_pkg::bin_t     push_data_i,
  input  logic               pop_i,
  output fsld_pkg::bin_t     pop_data_o,
  output fsld_pkg::q_stat_t  stat_o
);
  import fsld_pkg::*;

  bin_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? ((wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = pop_i ? ((rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  assign pop_data_o   = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

@@ rtl/core/fsld_back.sv @@
// back: log-sum-exp accumulation, frame result and output register
module fsld_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [fsld_pkg::LOG_W-1:0] ceiling_i,
  input  logic                              q_valid_i,
  input  fsld_pkg::bin_t                    q_data_i,
  output logic                              pop_o,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output logic signed [fsld_pkg::LOG_W-1:0] res_o
);
  import fsld_pkg::*;

  logic                    first_q, first_d;
  logic signed [SUM_W-1:0] clean_q, clean_d, other_q, other_d;
  logic                    fin_v_q, fin_v_d;
  logic signed [SUM_W-1:0] fin_clean_q, fin_other_q;
  mode_e                   fin_mode_q;
  logic                    out_v_q, out_v_d;
  logic signed [LOG_W-1:0] out_q, out_d;
  logic                    out_free, fin_free, fin_move;
  logic signed [SUM_W-1:0] hi, lo;
  logic signed [WIDE_W-1:0] diff, res_wide;

  assign out_free = !out_v_q || res_ready_i;
  assign fin_move = fin_v_q && out_free;
  assign fin_free = !fin_v_q || out_free;
  assign pop_o    = q_valid_i && (!q_data_i.last || fin_free);

  always_comb begin
    clean_d = clean_q;
    other_d = other_q;
    first_d = first_q;
    if (pop_o) begin
      first_d = q_data_i.last;
      if (first_q) begin
        clean_d = q_data_i.clean;
        other_d = q_data_i.other;
      end else begin
        clean_d = log_add(clean_q, q_data_i.clean);
        other_d = log_add(other_q, q_data_i.other);
      end
    end
    fin_v_d = (pop_o && q_data_i.last) || (fin_v_q && !out_free);
  end

  // frame result from the finished totals
  always_comb begin
    hi   = (fin_clean_q > fin_other_q) ? fin_clean_q : fin_other_q;
    lo   = (fin_clean_q > fin_other_q) ? fin_other_q : fin_clean_q;
    diff = WIDE_W'(hi) - WIDE_W'(lo);
    if (fin_mode_q == MODE_SNR) begin
      res_wide = WIDE_W'(fin_clean_q) - WIDE_W'(fin_other_q);
    end else if (fin_clean_q == fin_other_q) begin
      res_wide = WIDE_W'(ceiling_i);
    end else begin
      res_wide = WIDE_W'(fin_clean_q) - WIDE_W'(hi)
               + $signed({{(WIDE_W-TAB_W){1'b0}}, tab_read(SUB_TAB, diff[DIFF_W-1:0])});
    end
    out_d   = fin_move ? sat_log(res_wide) : out_q;
    out_v_d = fin_move || (out_v_q && !res_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      fin_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      first_q <= first_d;
      fin_v_q <= fin_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    clean_q <= clean_d;
    other_q <= other_d;
    out_q   <= out_d;
    if (pop_o && q_data_i.last) begin
      fin_clean_q <= clean_d;
      fin_other_q <= other_d;
      fin_mode_q  <= q_data_i.mode;
    end
  end

  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

endmodule

@@ bench/tb_frame_snr_log_domain_checker.sv @@
// checker: watches the bin, result and register channels, predicts and compares frame snr
module tb_frame_snr_log_domain_checker (
  input  logic clk_i,
  input  logic rst_ni,
  fsld_bin_if  bin_i,
  fsld_res_if  snr_i,
  fsld_cfg_if  cfg_i,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import fsld_pkg::*;

  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  longint softplus_tab [LOG_TABLE_DEPTH];
  longint logsub_tab [LOG_TABLE_DEPTH];

  mode_e                    cur_mode;
  logic signed [LOG_W-1:0]  ceiling;
  longint                   clean_acc;
  longint                   noise_acc;
  bit                       frame_start;
  logic signed [LOG_W-1:0]  snr_queue [$];
  int                       fails;

  assign fail_count_o = fails;
  assign pending_o    = snr_queue.size();

  function automatic longint unsigned minus_ln(longint unsigned m_in);
    longint unsigned m, z, z2, t, acc;
    m = m_in;
    if (m > ONE_Q30) m = ONE_Q30;
    if (m < (ONE_Q30 >> 1)) m = ONE_Q30 >> 1;
    z = ((ONE_Q30 - m) << 30) / (ONE_Q30 + m);
    z2 = (z * z) >> 30;
    t = z;
    acc = 0;
    for (int n = 0; n < 16; n++) begin
      acc += t / (2 * n + 1);
      t = (t * z2) >> 30;
    end
    return 2 * acc;
  endfunction

  function automatic longint unsigned minus_ln_wide(longint unsigned w_in,
                                                    longint unsigned ln_two);
    longint unsigned w, k;
    w = (w_in == 0) ? 1 : w_in;
    k = 0;
    while (w < (ONE_Q30 >> 1)) begin
      w = w << 1;
      k++;
    end
    return minus_ln(w) + k * ln_two;
  endfunction

  function automatic longint unsigned exp_step(int sh);
    longint unsigned acc, t;
    acc = ONE_Q30;
    t = ONE_Q30;
    for (int n = 1; n < 20; n++) begin
      t = (t >> sh) / n;
      acc += t;
    end
    return (64'd1 << 60) / acc;
  endfunction

  function automatic longint to_q8(longint unsigned v);
    return longint'((v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
  endfunction

  function automatic longint clamp(longint v, int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic longint tab_at(bit sub, longint d);
    longint idx;
    idx = (d < 0 ? 0 : d) >>> (FRAC_BITS - STEP_BITS);
    if (idx >= LOG_TABLE_DEPTH) return 0;
    return sub ? logsub_tab[idx] : softplus_tab[idx];
  endfunction

  function automatic longint log_sum(longint a, longint b);
    longint hi, lo;
    hi = (a > b) ? a : b;
    lo = (a > b) ? b : a;
    return clamp(hi + tab_at(1'b0, hi - lo), SUM_W);
  endfunction

  function automatic longint soft_plus(longint x);
    return (x > 0 ? x : 0) + tab_at(1'b0, x < 0 ? -x : x);
  endfunction

  initial begin
    longint unsigned ln_two, y, r, na;
    ln_two = minus_ln(ONE_Q30 >> 1);
    y = exp_step(STEP_BITS + 1);
    r = exp_step(STEP_BITS);
    for (int i = 0; i < LOG_TABLE_DEPTH; i++) begin
      na = minus_ln((ONE_Q30 + y) >> 1);
      softplus_tab[i] = to_q8(ln_two > na ? ln_two - na : 0);
      logsub_tab[i] = to_q8(minus_ln_wide(ONE_Q30 - y, ln_two));
      y = (y * r) >> 30;
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fails++;
  endtask

  // advance the frame state by one bin, return 1 and the result on a last bin
  function automatic bit frame_snr_step(longint f, longint p, bit last, output longint res);
    longint c, n, s, hi, lo;
    res = 0;
    if (cur_mode == MODE_MASK) begin
      c = clamp((p < 0 ? p : 0) + f, SUM_W);
      n = f;
    end else begin
      s = (p > ceiling) ? ceiling : p;
      c = clamp(2 * (f - soft_plus(-s)), SUM_W);
      n = clamp(2 * (f - soft_plus(s)), SUM_W);
    end
    if (frame_start) begin
      clean_acc = c;
      noise_acc = n;
    end else begin
      clean_acc = log_sum(clean_acc, c);
      noise_acc = log_sum(noise_acc, n);
    end
    frame_start = last;
    if (!last) return 1'b0;
    if (cur_mode == MODE_MASK) begin
      // equal totals mean no noise at all: report the ceiling
      if (clean_acc == noise_acc) begin
        res = ceiling;
      end else begin
        hi = (clean_acc > noise_acc) ? clean_acc : noise_acc;
        lo = (clean_acc > noise_acc) ? noise_acc : clean_acc;
        res = clean_acc - hi + tab_at(1'b1, hi - lo);
      end
    end else begin
      res = clean_acc - noise_acc;
    end
    res = clamp(res, LOG_W);
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    longint want;
    if (!rst_ni) begin
      cur_mode <= MODE_MASK;
      ceiling <= CEILING_RESET;
      clean_acc <= 0;
      noise_acc <= 0;
      frame_start <= 1'b1;
      snr_queue.delete();
      fails <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == REG_MODE) cur_mode = mode_e'(cfg_i.data[0]);
        else if (cfg_i.index == REG_CEILING) ceiling = cfg_i.data;
      end
      if (bin_i.valid && bin_i.ready) begin
        if (frame_snr_step(longint'(bin_i.noisy_log_energy), longint'(bin_i.prediction),
                           bin_i.last_bin, want))
          snr_queue.push_back(LOG_W'(want));
      end
      if (snr_i.valid && snr_i.ready) begin
        if (snr_queue.size() == 0) begin
          report_mismatch("unexpected frame_snr", longint'(snr_i.frame_snr), 0);
        end else begin
          want = longint'(snr_queue.pop_front());
          if (longint'(snr_i.frame_snr) != want)
            report_mismatch("frame_snr", longint'(snr_i.frame_snr), want);
        end
      end
    end
  end
endmodule

@@ bench/tb_frame_snr_log_domain.sv @@
// testbench top: stimulus, register phases and verdict for the frame snr estimator
module tb_frame_snr_log_domain;
  timeunit 1ns;
  timeprecision 1ps;
  import fsld_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 12;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycle = 0;
  int   fail_count;
  int   pending;
  int   bins_sent = 0;

  fsld_bin_if bin_if ();
  fsld_res_if snr_if ();
  fsld_cfg_if cfg_if ();

  frame_snr_log_domain i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .bin_i  (bin_if),
    .snr_o  (snr_if),
    .cfg_i  (cfg_if)
  );

  tb_frame_snr_log_domain_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .bin_i        (bin_if),
    .snr_i        (snr_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  // quiet window: no idling on either side
  function automatic bit quiet_window();
    return cycle >= 500 && cycle < 1000;
  endfunction

  // cycle counter and watchdog
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("[frame_snr_log_domain] ERROR");
      $finish;
    end
  end

  // result side stalls at random, about 12 in a hundred
  always @(posedge clk_i) begin
    if (quiet_window()) snr_if.ready <= 1'b1;
    else snr_if.ready <= ($urandom_range(99) >= 12);
  end

  initial begin
    bin_if.valid = 1'b0;
    bin_if.noisy_log_energy = '0;
    bin_if.prediction = '0;
    bin_if.last_bin = 1'b0;
    snr_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
  end

  // one bin transfer, optionally after a random gap
  task automatic send_bin(logic signed [15:0] f, logic signed [15:0] p, logic last);
    if (!quiet_window() && $urandom_range(99) < 12) begin
      bin_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    bin_if.valid <= 1'b1;
    bin_if.noisy_log_energy <= f;
    bin_if.prediction <= p;
    bin_if.last_bin <= last;
    do @(posedge clk_i); while (!bin_if.ready);
    bins_sent++;
  endtask

  // stop sending and wait until every frame result has come out
  task automatic drain();
    bin_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_value(int kind);
    case (kind)
      0: begin
        return 16'($urandom);
      end
      1: begin
        return 16'($urandom_range(4095)) - 16'd2048;
      end
      2: begin
        return $urandom_range(1) ? 16'h7fff : 16'h8000;
      end
      default: begin
        return 16'($urandom_range(255)) - 16'd128;
      end
    endcase
  endfunction

  task automatic random_frame();
    int len, kf, kp;
    len = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
    kf = $urandom_range(3);
    kp = $urandom_range(3);
    for (int i = 0; i < len; i++) begin
      // occasional broken frames mix field styles within a frame
      if ($urandom_range(15) == 0) kf = $urandom_range(3);
      send_bin(pick_value(kf), pick_value(kp), i == len - 1);
    end
  endtask

  initial begin
    logic [15:0] ceil_val;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // mask mode with reset registers: extremes, equal totals, large gaps
    send_bin(16'sh7fff, 16'sh7fff, 1'b1);
    send_bin(-16'sh8000, -16'sh8000, 1'b1);
    send_bin(16'sd0, 16'sd0, 1'b1);
    send_bin(16'sd100, -16'sd300, 1'b0);
    send_bin(16'sd50, -16'sd10, 1'b0);
    send_bin(16'sd60, 16'sd20, 1'b1);
    send_bin(16'sh7fff, 16'sd0, 1'b0);
    send_bin(-16'sh8000, -16'sh8000, 1'b1);
    send_bin(16'sd1000, -16'sd256, 1'b0);
    // mode change in the middle of a frame
    drain();
    write_reg(REG_MODE, 16'(MODE_SNR));
    send_bin(16'sd500, 16'sd300, 1'b1);
    // snr mode: capped prediction, saturating sums
    send_bin(16'sh7fff, 16'sh7fff, 1'b0);
    send_bin(-16'sh8000, -16'sh8000, 1'b1);
    send_bin(16'sd0, 16'sd0, 1'b1);
    drain();
    write_reg(REG_CEILING, 16'h8000);
    send_bin(16'sd1200, 16'sh7fff, 1'b1);
    send_bin(-16'sd1200, 16'sd0, 1'b1);
    drain();
    write_reg(REG_CEILING, 16'h7fff);
    send_bin(16'sd1200, 16'sh7fff, 1'b0);
    send_bin(16'sd100, -16'sh8000, 1'b1);
    drain();
    // out-of-range register indexes are ignored
    write_reg(8'd2, 16'h0000);
    write_reg(8'hff, 16'hffff);
    write_reg(REG_MODE, 16'(MODE_MASK));
    send_bin(16'sd0, 16'sd0, 1'b1);
    send_bin(16'sd300, -16'sd5000, 1'b1);
    drain();
    write_reg(REG_CEILING, 16'h8000);
    send_bin(16'sd10, 16'sd10, 1'b1);

    // random phases, each under its own register setting
    while (bins_sent < 800) begin
      drain();
      case ($urandom_range(3))
        0: ceil_val = 16'h7fff;
        1: ceil_val = 16'h8000;
        2: ceil_val = 16'(CEILING_RESET);
        default: ceil_val = 16'($urandom);
      endcase
      write_reg(REG_MODE, 16'($urandom_range(1)));
      write_reg(REG_CEILING, ceil_val);
      repeat ($urandom_range(10, 30)) random_frame();
    end

    drain();
    if (fail_count == 0) begin
      $display("[frame_snr_log_domain] OK");
    end else begin
      $display("[frame_snr_log_domain] ERROR");
    end
    $finish;
  end
endmodule
